// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers included by the self-checking protocol engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, skipped while reset is held.
`define SFBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked in the next cycle, skipped while reset is held.
`define SFBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sfbp_pkg.sv =====
package sfbp_pkg;

  // Default flash page size in bytes.
  localparam int PageBytesDef = 32;

  // Protocol characters.
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_GREET = 8'h62;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h00;
  localparam logic [7:0] CH_ADDR  = 8'h02;

  // Result kinds.
  typedef enum logic [2:0] {
    RK_TX    = 3'd0,
    RK_ERASE = 3'd1,
    RK_FILL  = 3'd2,
    RK_WRITE = 3'd3,
    RK_BURST = 3'd4,
    RK_RESET = 3'd5
  } rk_e;

  // Source of the transmit byte.
  typedef enum logic [1:0] {
    TX_CONST = 2'd0,
    TX_AHI   = 2'd1,
    TX_ALO   = 2'd2,
    TX_RLEN  = 2'd3
  } txsel_e;

  // Datapath action of a step.
  typedef enum logic [2:0] {
    A_NONE = 3'd0,
    A_CLR  = 3'd1,
    A_RLO  = 3'd2,
    A_RHI  = 3'd3,
    A_CAP  = 3'd4,
    A_INC  = 3'd5
  } act_e;

  // Sequencing of the next step.
  typedef enum logic [1:0] {
    J_NEXT = 2'd0,
    J_GOTO = 2'd1,
    J_LOOP = 2'd2
  } jmp_e;

  typedef logic [4:0] step_t;

  // Program step addresses.
  localparam step_t ST_FETCH = 5'd0;
  localparam step_t ST_COLON = 5'd1;
  localparam step_t ST_GREET = 5'd2;
  localparam step_t ST_RSTRQ = 5'd3;
  localparam step_t ST_A0    = 5'd4;
  localparam step_t ST_A1    = 5'd5;
  localparam step_t ST_A2    = 5'd6;
  localparam step_t ST_A3    = 5'd7;
  localparam step_t ST_P0    = 5'd8;
  localparam step_t ST_P1    = 5'd9;
  localparam step_t ST_P2    = 5'd10;
  localparam step_t ST_P3    = 5'd11;
  localparam step_t ST_P4    = 5'd12;
  localparam step_t ST_P5    = 5'd13;
  localparam step_t ST_P6    = 5'd14;
  localparam step_t ST_P7    = 5'd15;
  localparam step_t ST_R0    = 5'd16;
  localparam step_t ST_R1    = 5'd17;
  localparam step_t ST_R2    = 5'd18;
  localparam step_t ST_Q0    = 5'd19;
  localparam step_t ST_Q1    = 5'd20;

  // One control word of the program.
  typedef struct packed {
    logic       emit;
    logic       last;
    rk_e        rk;
    txsel_e     txsel;
    logic [7:0] txc;
    act_e       act;
    jmp_e       jmp;
    step_t      target;
  } uword_t;

  function automatic uword_t uc_word(input logic e, input logic l, input rk_e k,
                                     input txsel_e ts, input logic [7:0] c,
                                     input act_e a, input jmp_e j, input step_t t);
    uword_t w;
    w.emit   = e;
    w.last   = l;
    w.rk     = k;
    w.txsel  = ts;
    w.txc    = c;
    w.act    = a;
    w.jmp    = j;
    w.target = t;
    return w;
  endfunction

  // Control store: the reply programs of every command.
  function automatic uword_t uc_rom(input step_t s);
    uword_t w;
    case (s)
      ST_COLON: w = uc_word(1'b1, 1'b1, RK_TX, TX_CONST, CH_COLON, A_NONE, J_GOTO, ST_FETCH);
      ST_GREET: w = uc_word(1'b1, 1'b1, RK_TX, TX_CONST, CH_GREET, A_NONE, J_GOTO, ST_FETCH);
      ST_RSTRQ: w = uc_word(1'b1, 1'b1, RK_RESET, TX_CONST, CH_ZERO, A_NONE, J_GOTO, ST_FETCH);
      ST_A0:    w = uc_word(1'b1, 1'b0, RK_TX, TX_CONST, CH_SEMI, A_NONE, J_NEXT, ST_FETCH);
      ST_A1:    w = uc_word(1'b1, 1'b0, RK_TX, TX_CONST, CH_ADDR, A_NONE, J_NEXT, ST_FETCH);
      ST_A2:    w = uc_word(1'b1, 1'b0, RK_TX, TX_AHI, CH_ZERO, A_NONE, J_NEXT, ST_FETCH);
      ST_A3:    w = uc_word(1'b1, 1'b0, RK_TX, TX_ALO, CH_ZERO, A_NONE, J_GOTO, ST_COLON);
      ST_P0:    w = uc_word(1'b1, 1'b0, RK_TX, TX_CONST, CH_SEMI, A_NONE, J_NEXT, ST_FETCH);
      ST_P1:    w = uc_word(1'b1, 1'b0, RK_TX, TX_CONST, CH_ZERO, A_NONE, J_NEXT, ST_FETCH);
      ST_P2:    w = uc_word(1'b1, 1'b0, RK_ERASE, TX_CONST, CH_ZERO, A_CLR, J_NEXT, ST_FETCH);
      ST_P3:    w = uc_word(1'b0, 1'b0, RK_TX, TX_CONST, CH_ZERO, A_RLO, J_NEXT, ST_FETCH);
      ST_P4:    w = uc_word(1'b0, 1'b0, RK_TX, TX_CONST, CH_ZERO, A_RHI, J_NEXT, ST_FETCH);
      ST_P5:    w = uc_word(1'b0, 1'b0, RK_TX, TX_CONST, CH_ZERO, A_CAP, J_NEXT, ST_FETCH);
      ST_P6:    w = uc_word(1'b1, 1'b0, RK_FILL, TX_CONST, CH_ZERO, A_INC, J_LOOP, ST_P3);
      ST_P7:    w = uc_word(1'b1, 1'b0, RK_WRITE, TX_CONST, CH_ZERO, A_NONE, J_GOTO, ST_COLON);
      ST_R0:    w = uc_word(1'b1, 1'b0, RK_TX, TX_CONST, CH_SEMI, A_NONE, J_NEXT, ST_FETCH);
      ST_R1:    w = uc_word(1'b1, 1'b0, RK_TX, TX_RLEN, CH_ZERO, A_NONE, J_NEXT, ST_FETCH);
      ST_R2:    w = uc_word(1'b1, 1'b0, RK_BURST, TX_CONST, CH_ZERO, A_NONE, J_GOTO, ST_COLON);
      ST_Q0:    w = uc_word(1'b1, 1'b0, RK_TX, TX_CONST, CH_SEMI, A_NONE, J_NEXT, ST_FETCH);
      ST_Q1:    w = uc_word(1'b1, 1'b0, RK_TX, TX_CONST, CH_ZERO, A_NONE, J_GOTO, ST_COLON);
      default:  w = uc_word(1'b0, 1'b0, RK_TX, TX_CONST, CH_ZERO, A_NONE, J_GOTO, ST_FETCH);
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/serial_flash_bootloader_protocol.sv =====
// Serial bootloader command engine. Each input transaction is one received UART byte
// (tuser low) or a start-up event (tuser high, replies 'b'). Command bytes, lengths,
// addresses and page data that cause no reply are accepted without running a program.
// A reply is run by a small microprogram that issues its output transactions in turn,
// stalling while the output side is not ready; the block takes the next input once the
// last result of the previous one has been handed to the output register. A page command
// reply reads every fill word through the single read port of the page buffer in two
// read steps and a capture step. The page buffer reads as all 0xFF after reset without
// any clearing pass.
`include "assert_macros.svh"

module serial_flash_bootloader_protocol
  import sfbp_pkg::*;
#(
  parameter int PAGE_BYTES = PageBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [7:0] tx_byte, [20:8] flash_addr,
                                        // [36:21] fill_word, [45:37] burst_count
  output logic [2:0]  m_axis_tuser_o,   // [2:0] res_kind
  output logic        m_axis_tlast_o    // last
);

  localparam int AW  = $clog2(PAGE_BYTES);
  localparam int WIW = AW - 1;
  localparam logic [8:0] PageLen   = 9'(PAGE_BYTES);
  localparam logic [8:0] PageWords = 9'(PAGE_BYTES / 2);

  typedef enum logic [9:0] {
    PH_IDLE   = 10'b0000000001,
    PH_A_ADDR = 10'b0000000010,
    PH_A_TERM = 10'b0000000100,
    PH_P_LEN  = 10'b0000001000,
    PH_P_DATA = 10'b0000010000,
    PH_P_TERM = 10'b0000100000,
    PH_R_LEN  = 10'b0001000000,
    PH_R_TERM = 10'b0010000000,
    PH_Q_TERM = 10'b0100000000,
    PH_HALT   = 10'b1000000000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [12:0]     load_q, load_d;
  logic [8:0]      cnt_q, cnt_d;
  logic [8:0]      slen_q, slen_d;
  logic [7:0]      rlen_q, rlen_d;
  logic [WIW-1:0]  widx_q;
  logic [7:0]      lo_q, hi_q;
  logic [PAGE_BYTES-1:0] valid_q;
  logic            rvalid_q;

  logic            at_fetch, in_acc, start, hold, more, out_load;
  step_t           entry;
  uword_t          uw;

  logic            buf_we;
  logic [8:0]      buf_idx;
  logic            buf_re;
  logic [AW-1:0]   buf_raddr;
  logic [7:0]      buf_rdata, rd_byte;
  logic [8:0]      words_full, words;

  logic            out_valid_q;
  logic [2:0]      out_kind_q;
  logic [47:0]     out_data_q;
  logic            out_last_q;
  logic [7:0]      res_tx;
  logic [12:0]     res_addr;
  logic [15:0]     res_word;
  logic [8:0]      res_burst;

  assign s_axis_tready_o = at_fetch;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign hold            = uw.emit && out_valid_q && !m_axis_tready_i;
  assign out_load        = !at_fetch && uw.emit && !hold;

  // Byte-level protocol tracking and dispatch into the reply programs.
  always_comb begin
    phase_d = phase_q;
    load_d  = load_q;
    cnt_d   = cnt_q;
    slen_d  = slen_q;
    rlen_d  = rlen_q;
    start   = 1'b0;
    entry   = ST_FETCH;
    buf_we  = 1'b0;
    buf_idx = slen_q - cnt_q;
    if (in_acc) begin
      if (s_axis_tuser_i) begin
        phase_d = PH_IDLE;
        start   = 1'b1;
        entry   = ST_GREET;
      end else begin
        case (phase_q)
          PH_HALT: begin
            phase_d = PH_HALT;
          end
          PH_A_ADDR: begin
            load_d  = {s_axis_tdata_i, 5'b00000};
            phase_d = PH_A_TERM;
          end
          PH_P_LEN: begin
            slen_d  = (s_axis_tdata_i == CH_ZERO) ? 9'd256 : {1'b0, s_axis_tdata_i};
            cnt_d   = slen_d;
            phase_d = PH_P_DATA;
          end
          PH_P_DATA: begin
            buf_we = (buf_idx < PageLen);
            cnt_d  = cnt_q - 9'd1;
            if (cnt_d == 9'd0) begin
              phase_d = PH_P_TERM;
            end
          end
          PH_R_LEN: begin
            rlen_d  = s_axis_tdata_i;
            phase_d = PH_R_TERM;
          end
          PH_A_TERM, PH_P_TERM, PH_R_TERM, PH_Q_TERM: begin
            start = 1'b1;
            if (s_axis_tdata_i != CH_SPACE) begin
              entry   = ST_RSTRQ;
              phase_d = PH_HALT;
            end else begin
              phase_d = PH_IDLE;
              case (phase_q)
                PH_A_TERM: entry = ST_A0;
                PH_P_TERM: entry = ST_P0;
                PH_R_TERM: entry = ST_R0;
                default:   entry = ST_Q0;
              endcase
            end
          end
          default: begin
            phase_d = PH_IDLE;
            if (s_axis_tdata_i == CH_A) begin
              phase_d = PH_A_ADDR;
            end else if (s_axis_tdata_i == CH_P) begin
              phase_d = PH_P_LEN;
            end else if (s_axis_tdata_i == CH_R) begin
              phase_d = PH_R_LEN;
            end else if (s_axis_tdata_i == CH_Q) begin
              phase_d = PH_Q_TERM;
            end else begin
              start = 1'b1;
              entry = ST_COLON;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      load_q  <= '0;
      cnt_q   <= '0;
      slen_q  <= '0;
      rlen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      load_q  <= load_d;
      cnt_q   <= cnt_d;
      slen_q  <= slen_d;
      rlen_q  <= rlen_d;
    end
  end

  sfbp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .entry_i    (entry),
    .more_i     (more),
    .hold_i     (hold),
    .at_fetch_o (at_fetch),
    .uw_o       (uw)
  );

  // Page buffer: writes while data bytes arrive, reads during the fill loop.
  assign buf_re    = !at_fetch && ((uw.act == A_RLO) || (uw.act == A_RHI));
  assign buf_raddr = {widx_q, (uw.act == A_RHI)};

  sfbp_ram #(
    .Width (8),
    .Depth (PAGE_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_idx[AW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // Entries never written since reset read as erased flash.
  assign rd_byte = rvalid_q ? buf_rdata : 8'hFF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (buf_we) begin
        valid_q[buf_idx[AW-1:0]] <= 1'b1;
      end
      if (buf_re) begin
        rvalid_q <= valid_q[buf_raddr];
      end
    end
  end

  // Fill loop: word index and the two captured bytes of the current word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
    end else if (!at_fetch && !hold) begin
      if (uw.act == A_CLR) begin
        widx_q <= '0;
      end else if (uw.act == A_INC) begin
        widx_q <= widx_q + WIW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!at_fetch && (uw.act == A_RHI)) begin
      lo_q <= rd_byte;
    end
    if (!at_fetch && (uw.act == A_CAP)) begin
      hi_q <= rd_byte;
    end
  end

  // Odd lengths round up to a word; the page caps the word count.
  assign words_full = 9'((10'(slen_q) + 10'd1) >> 1);
  assign words      = (words_full > PageWords) ? PageWords : words_full;
  assign more       = ((9'(widx_q) + 9'd1) < words);

  // Result fields of the current step.
  always_comb begin
    case (uw.txsel)
      TX_AHI:  res_tx = {3'b000, load_q[12:8]};
      TX_ALO:  res_tx = load_q[7:0];
      TX_RLEN: res_tx = rlen_q;
      default: res_tx = uw.txc;
    endcase
    case (uw.rk)
      RK_ERASE, RK_WRITE, RK_BURST: res_addr = load_q;
      RK_FILL: res_addr = load_q + 13'({widx_q, 1'b0});
      default: res_addr = '0;
    endcase
    res_word  = (uw.rk == RK_FILL) ? {hi_q, lo_q} : 16'h0000;
    res_burst = (uw.rk == RK_BURST) ? ({1'b0, rlen_q} + 9'd1) : 9'd0;
  end

  // Output register: the next result loads when the slot is free or being taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= uw.rk;
      out_data_q <= {2'b00, res_burst, res_word, res_addr, res_tx};
      out_last_q <= uw.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // A pending result is never overwritten while the consumer stalls.
  `SFBP_ASSERT(a_no_overwrite, (out_valid_q && !m_axis_tready_i) |-> !out_load,
               "result overwritten while stalled")
  // The last result of a program returns the sequencer to fetch.
  `SFBP_ASSERT_NEXT(a_last_ends, out_load && uw.last, at_fetch,
                    "program did not end after its last result")
  // A halted engine ignores received bytes.
  `SFBP_ASSERT_NEXT(a_halt_quiet, in_acc && !s_axis_tuser_i && (phase_q == PH_HALT),
                    at_fetch && (phase_q == PH_HALT), "halted engine reacted to a byte")

endmodule

// ===== hw/rtl/sfbp_ram.sv =====
module sfbp_ram
  import sfbp_pkg::*;
#(
  parameter int Width = 8,
  parameter int Depth = PageBytesDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sfbp_seq.sv =====
module sfbp_seq
  import sfbp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  step_t  entry_i,
  input  logic   more_i,
  input  logic   hold_i,
  output logic   at_fetch_o,
  output uword_t uw_o
);

  step_t  step_q, step_d;
  uword_t uw;

  // Control word of the current step.
  assign uw         = uc_rom(step_q);
  assign uw_o       = uw;
  assign at_fetch_o = (step_q == ST_FETCH);

  // Step counter with dispatch and conditional jumps.
  always_comb begin
    step_d = step_q;
    if (step_q == ST_FETCH) begin
      if (start_i) begin
        step_d = entry_i;
      end
    end else if (!hold_i) begin
      case (uw.jmp)
        J_NEXT:  step_d = step_q + 5'd1;
        J_GOTO:  step_d = uw.target;
        J_LOOP:  step_d = more_i ? uw.target : step_q + 5'd1;
        default: step_d = ST_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
